@@ design/glyph_bitmap_to_argb1555_defines.svh @@
// Assertion macros shared by the glyph bitmap to ARGB1555 converter.
// Included by gbta_back, the only module that carries concurrent assertions.
`ifndef GLYPH_BITMAP_TO_ARGB1555_DEFINES_SVH
`define GLYPH_BITMAP_TO_ARGB1555_DEFINES_SVH

// Checked at every rising edge, masked while reset is asserted.
`define GBTA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising edge, including during reset.
`define GBTA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ design/gbta_pkg.sv @@
// Package for the glyph bitmap to ARGB1555 converter: types, constants,
// register map and the pixel to texel expansion. No dependencies.
`timescale 1ns / 1ps

package gbta_pkg;

    localparam int DEF_MAX_GLYPH_WIDTH  = 64;
    localparam int DEF_MAX_GLYPH_HEIGHT = 64;
    localparam int DEF_MAX_GLYPHS       = 256;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 20;
    localparam int TEXEL_W  = 16;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [6:0] RST_GLYPH_WIDTH  = 7'd8;
    localparam logic [6:0] RST_GLYPH_HEIGHT = 7'd8;
    localparam logic [8:0] RST_GLYPH_COUNT  = 9'd256;

    typedef enum logic [2:0] {
        REG_BPP_LOG2     = 3'd0,
        REG_MSB_FIRST    = 3'd1,
        REG_GLYPH_WIDTH  = 3'd2,
        REG_GLYPH_HEIGHT = 3'd3,
        REG_GLYPH_COUNT  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] bpp_log2;
        logic       msb_first;
        logic [6:0] glyph_width;
        logic [6:0] glyph_height;
        logic [8:0] glyph_count;
    } cfg_t;

    // One source byte after classification: texel count, first index, end flag.
    typedef struct packed {
        logic [7:0]       font_byte;
        logic [3:0]       n;
        logic [IDX_W-1:0] base_index;
        logic             font_done;
    } job_t;

    function automatic logic [TEXEL_W-1:0] texel_of(input logic [7:0] pix,
                                                    input logic [1:0] bpp_log2);
        logic [7:0] grey;
        logic [4:0] g;
        grey = 8'd0;
        unique case (bpp_log2)
            2'd0: grey = pix[0] ? 8'd255 : 8'd0;
            2'd1: grey = 8'(pix[1:0] * 8'd85);
            2'd2: grey = 8'(pix[3:0] * 8'd17);
            2'd3: grey = pix;
        endcase
        g = grey[7:3];
        return (grey == 8'd0) ? 16'd0 : {1'b1, g, g, g};
    endfunction

endpackage

@@ design/gbta_if.sv @@
// Channel interfaces: packed source bytes in, texels out.
// Standalone; valid/ready handshake, one beat per accepted item.
`timescale 1ns / 1ps

interface gbta_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] font_byte;
    logic       new_font;

    modport source (output valid, font_byte, new_font, input ready);
    modport sink   (input valid, font_byte, new_font, output ready);
endinterface

interface gbta_texel_if;
    logic        valid;
    logic        ready;
    logic [15:0] texel;
    logic [19:0] texel_index;
    logic        last;
    logic        font_done;

    modport source (output valid, texel, texel_index, last, font_done, input ready);
    modport sink   (input valid, texel, texel_index, last, font_done, output ready);
endinterface

@@ design/gbta_regs.sv @@
// APB configuration registers of the converter.
// Depends on gbta_pkg.
`timescale 1ns / 1ps

module gbta_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbta_pkg::ADDR_W-1:0]   paddr,
    input  logic [gbta_pkg::DATA_W-1:0]   pwdata,
    output logic [gbta_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output gbta_pkg::cfg_t                cfg
);
    import gbta_pkg::*;

    logic [1:0] bpp_log2_reg, bpp_log2_next;
    logic       msb_first_reg, msb_first_next;
    logic [6:0] width_reg, width_next;
    logic [6:0] height_reg, height_next;
    logic [8:0] count_reg, count_next;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        bpp_log2_next  = bpp_log2_reg;
        msb_first_next = msb_first_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        count_next     = count_reg;
        if (wr_en)
        begin
            case (idx)
                REG_BPP_LOG2:     bpp_log2_next  = pwdata[1:0];
                REG_MSB_FIRST:    msb_first_next = pwdata[0];
                REG_GLYPH_WIDTH:  width_next     = pwdata[6:0];
                REG_GLYPH_HEIGHT: height_next    = pwdata[6:0];
                REG_GLYPH_COUNT:  count_next     = pwdata[8:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BPP_LOG2:     prdata = DATA_W'(bpp_log2_reg);
            REG_MSB_FIRST:    prdata = DATA_W'(msb_first_reg);
            REG_GLYPH_WIDTH:  prdata = DATA_W'(width_reg);
            REG_GLYPH_HEIGHT: prdata = DATA_W'(height_reg);
            REG_GLYPH_COUNT:  prdata = DATA_W'(count_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_log2_reg  <= 2'd0;
            msb_first_reg <= 1'b0;
            width_reg     <= RST_GLYPH_WIDTH;
            height_reg    <= RST_GLYPH_HEIGHT;
            count_reg     <= RST_GLYPH_COUNT;
        end
        else
        begin
            bpp_log2_reg  <= bpp_log2_next;
            msb_first_reg <= msb_first_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            count_reg     <= count_next;
        end
    end

    assign cfg = '{bpp_log2:     bpp_log2_reg,
                   msb_first:    msb_first_reg,
                   glyph_width:  width_reg,
                   glyph_height: height_reg,
                   glyph_count:  count_reg};

endmodule

@@ design/gbta_front.sv @@
// Front end: accepts source bytes, tracks column/row/glyph position and
// turns each byte into a job for the queue. Depends on gbta_pkg, gbta_if.
`timescale 1ns / 1ps

module gbta_front #(
    parameter int MAX_GLYPH_WIDTH  = gbta_pkg::DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = gbta_pkg::DEF_MAX_GLYPH_HEIGHT,
    parameter int MAX_GLYPHS       = gbta_pkg::DEF_MAX_GLYPHS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gbta_pkg::cfg_t cfg,
    gbta_byte_if.sink      font,
    input  logic           q_full,
    output logic           push,
    output gbta_pkg::job_t job
);
    import gbta_pkg::*;

    localparam int COL_W = $clog2(MAX_GLYPH_WIDTH);
    localparam int ROW_W = $clog2(MAX_GLYPH_HEIGHT);
    localparam int GN_W  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [GN_W-1:0]  gn_reg, gn_next;
    logic [IDX_W-1:0] base_reg, base_next;

    logic [8:0]  w_eff, h_eff, cnt_eff;
    logic [8:0]  col_cur, row_cur, gn_cur, rem, col_sum, row_sum, gn_sum;
    logic [IDX_W-1:0] base_cur, base_adv;
    logic [3:0]  ppb, n;
    logic [17:0] row_off, area;
    logic        wrap_col, wrap_row, wrap_gn;

    function automatic logic [8:0] clamp(input logic [8:0] v, input int hi);
        logic [8:0] r;
        r = v;
        if (v == 9'd0)
            r = 9'd1;
        else if (v > 9'(hi))
            r = 9'(hi);
        return r;
    endfunction

    assign font.ready = !q_full;
    assign push       = font.valid && font.ready;

    always_comb
    begin
        w_eff   = clamp({2'b00, cfg.glyph_width}, MAX_GLYPH_WIDTH);
        h_eff   = clamp({2'b00, cfg.glyph_height}, MAX_GLYPH_HEIGHT);
        cnt_eff = clamp(cfg.glyph_count, MAX_GLYPHS);

        col_cur = (font.new_font || 9'(col_reg) >= w_eff) ? 9'd0 : 9'(col_reg);
        row_cur = (font.new_font || 9'(row_reg) >= h_eff) ? 9'd0 : 9'(row_reg);
        if (font.new_font || 9'(gn_reg) >= cnt_eff)
        begin
            gn_cur   = 9'd0;
            base_cur = '0;
        end
        else
        begin
            gn_cur   = 9'(gn_reg);
            base_cur = base_reg;
        end

        ppb = 4'd8 >> cfg.bpp_log2;
        rem = w_eff - col_cur;
        n   = (rem < 9'(ppb)) ? rem[3:0] : ppb;

        row_off  = 18'(row_cur) * 18'(w_eff);
        area     = 18'(w_eff) * 18'(h_eff);
        base_adv = (base_cur + IDX_W'(area) + IDX_W'(7)) & ~IDX_W'(7);

        col_sum  = col_cur + 9'(n);
        row_sum  = row_cur + 9'd1;
        gn_sum   = gn_cur + 9'd1;
        wrap_col = col_sum >= w_eff;
        wrap_row = row_sum >= h_eff;
        wrap_gn  = gn_sum >= cnt_eff;

        col_next  = wrap_col ? '0 : col_sum[COL_W-1:0];
        row_next  = row_cur[ROW_W-1:0];
        gn_next   = gn_cur[GN_W-1:0];
        base_next = base_cur;
        if (wrap_col)
        begin
            row_next = wrap_row ? '0 : row_sum[ROW_W-1:0];
            if (wrap_row)
            begin
                gn_next   = wrap_gn ? '0 : gn_sum[GN_W-1:0];
                base_next = wrap_gn ? '0 : base_adv;
            end
        end

        job.font_byte  = font.font_byte;
        job.n          = n;
        job.base_index = base_cur + IDX_W'(row_off) + IDX_W'(col_cur);
        job.font_done  = wrap_col && wrap_row && wrap_gn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            gn_reg   <= '0;
            base_reg <= '0;
        end
        else if (push)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            gn_reg   <= gn_next;
            base_reg <= base_next;
        end
    end

endmodule

@@ design/gbta_queue.sv @@
// Short job queue between front and back end.
// Depends on gbta_pkg.
`timescale 1ns / 1ps

module gbta_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gbta_pkg::job_t job_in,
    input  logic           pop,
    output gbta_pkg::job_t head,
    output logic           empty,
    output logic           full
);
    import gbta_pkg::*;

    job_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= job_in;
    end

endmodule

@@ design/gbta_back.sv @@
// Back end: walks the pixels of the queue head, expands each to a texel
// and drives the output register. Depends on gbta_pkg, gbta_if, defines.
`timescale 1ns / 1ps
`include "glyph_bitmap_to_argb1555_defines.svh"

module gbta_back (
    input  logic           clk,
    input  logic           rst_n,
    input  gbta_pkg::cfg_t cfg,
    input  gbta_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    gbta_texel_if.source   texels
);
    import gbta_pkg::*;

    logic [2:0]         k_reg, k_next;
    logic               ov_reg, ov_next;
    logic [TEXEL_W-1:0] texel_reg, texel_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               last_reg, last_next;
    logic               done_reg, done_next;

    logic       emit, is_last;
    logic [2:0] sh;
    logic [5:0] k_off;
    logic [5:0] k1_off;
    logic [7:0] pmask, pix;

    always_comb
    begin
        emit    = !empty && (!ov_reg || texels.ready);
        is_last = ({1'b0, k_reg} + 4'd1) == head.n;
        pop     = emit && is_last;

        k_off  = 6'(k_reg) << cfg.bpp_log2;
        k1_off = (6'(k_reg) + 6'd1) << cfg.bpp_log2;
        sh     = cfg.msb_first ? 3'(6'd8 - k1_off) : k_off[2:0];
        pmask  = 8'((9'd1 << (4'd1 << cfg.bpp_log2)) - 9'd1);
        pix    = (head.font_byte >> sh) & pmask;

        k_next     = k_reg;
        ov_next    = ov_reg && !texels.ready;
        texel_next = texel_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (emit)
        begin
            k_next     = is_last ? 3'd0 : k_reg + 3'd1;
            ov_next    = 1'b1;
            texel_next = texel_of(pix, cfg.bpp_log2);
            idx_next   = head.base_index + IDX_W'(k_reg);
            last_next  = is_last;
            done_next  = is_last && head.font_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            k_reg  <= k_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        texel_reg <= texel_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        done_reg  <= done_next;
    end

    assign texels.valid       = ov_reg;
    assign texels.texel       = texel_reg;
    assign texels.texel_index = idx_reg;
    assign texels.last        = last_reg;
    assign texels.font_done   = done_reg;

    `GBTA_ASSERT(a_k_in_job, clk, rst_n, !empty |-> ({1'b0, k_reg} < head.n), "pixel count past job")
    `GBTA_ASSERT(a_done_on_last, clk, rst_n, ov_reg |-> (!done_reg || last_reg), "font_done off last beat")
    `GBTA_ASSERT(a_grey_equal, clk, rst_n, ov_reg |-> (texel_reg[14:10] == texel_reg[9:5] && texel_reg[9:5] == texel_reg[4:0] && (texel_reg[15] || texel_reg == '0)), "texel not grey")
    `GBTA_ASSERT(a_index_step, clk, rst_n, (ov_reg && texels.ready && !last_reg) |=> (!ov_reg || idx_reg == $past(idx_reg) + IDX_W'(1)), "texel index not consecutive")

endmodule

@@ design/glyph_bitmap_to_argb1555.sv @@
// The first texel of a byte passes through the job queue, then the output register.
// Throughput: one texel per cycle from the single output register while texels.ready
//   is high; a byte yields min(8 >> bpp_log2, pixels left in the row) texels.
// A 4-entry job queue lets the byte side run ahead of a stalled texel side.
// Reset (rst_n low, asynchronous): position counters, queue and output valid
//   clear; configuration registers return to 1 bpp, LSB-first, 8x8, 256 glyphs.
`timescale 1ns / 1ps

module glyph_bitmap_to_argb1555 #(
    parameter int MAX_GLYPH_WIDTH  = gbta_pkg::DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = gbta_pkg::DEF_MAX_GLYPH_HEIGHT,
    parameter int MAX_GLYPHS       = gbta_pkg::DEF_MAX_GLYPHS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    gbta_byte_if.sink                     font,
    gbta_texel_if.source                  texels,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbta_pkg::ADDR_W-1:0]   paddr,
    input  logic [gbta_pkg::DATA_W-1:0]   pwdata,
    output logic [gbta_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gbta_pkg::*;

    cfg_t cfg;
    job_t job, head;
    logic push, pop, empty, full;

    gbta_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gbta_front #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .MAX_GLYPHS       (MAX_GLYPHS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .font   (font),
        .q_full (full),
        .push   (push),
        .job    (job)
    );

    gbta_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job),
        .pop    (pop),
        .head   (head),
        .empty  (empty),
        .full   (full)
    );

    gbta_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .texels (texels)
    );

endmodule
